FILE: hdl/http_response_deframer_core_defines.svh
// Assertion macros shared by the deframer RTL.
`ifndef HTTP_RESPONSE_DEFRAMER_CORE_DEFINES_SVH
`define HTTP_RESPONSE_DEFRAMER_CORE_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define HRD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define HRD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/hrd_pkg.sv
// Types, constants and helper functions of the HTTP response deframer.
package hrd_pkg;

  localparam int LENGTH_BITS_DEFAULT = 32;

  typedef enum logic [7:0] {
    PH_STATUS      = 8'b0000_0001,
    PH_HEADER      = 8'b0000_0010,
    PH_LENGTH      = 8'b0000_0100,
    PH_UNTIL_CLOSE = 8'b0000_1000,
    PH_SIZE        = 8'b0001_0000,
    PH_DATA        = 8'b0010_0000,
    PH_GAP         = 8'b0100_0000,
    PH_TRAILER     = 8'b1000_0000
  } phase_t;

  typedef enum logic [1:0] {
    KIND_BODY  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic {
    OP_DATA  = 1'b0,
    OP_CLOSE = 1'b1
  } op_t;

  localparam int CAND_CL   = 0;
  localparam int CAND_TE   = 1;
  localparam int CAND_CONN = 2;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X_LO  = 8'h78;
  localparam logic [7:0] CH_X_UP  = 8'h58;

  localparam logic [8*14-1:0] NAME_CL   = "content-length";
  localparam logic [8*17-1:0] NAME_TE   = "transfer-encoding";
  localparam logic [8*10-1:0] NAME_CONN = "connection";
  localparam logic [8*7-1:0]  WORD_CHUNKED = "chunked";
  localparam logic [8*7-1:0]  WORD_CLOSE   = {"close", 16'h0000};
  localparam logic [2:0]      LEN_CHUNKED  = 3'd7;
  localparam logic [2:0]      LEN_CLOSE    = 3'd5;

  localparam logic [9:0] CODE_MAX = 10'd999;

  typedef struct packed {
    phase_t     phase;
    logic       held_cr;
    logic [1:0] space_count;
    logic [9:0] code_value;
    logic       line_nonempty;
    logic       colon_seen;
    logic [4:0] key_position;
    logic [2:0] key_candidates;
    logic       key_gap;
    logic [2:0] chunked_match;
    logic [2:0] close_match;
    logic       length_valid;
    logic       chunked_flag;
    logic       keep_flag;
    logic       size_done;
  } hrd_state_t;

  localparam hrd_state_t HRD_STATE_RESET = '{
    phase: PH_STATUS, key_candidates: 3'b111, keep_flag: 1'b1, default: '0};

  typedef struct packed {
    kind_t      result_kind;
    logic [7:0] body_byte;
    logic [9:0] resp_code;
    logic       reuse_ok;
    logic       last;
  } hrd_result_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_dig(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

  // Returns 16 for a byte that is not a hex digit.
  function automatic logic [4:0] hexval(input logic [7:0] c);
    logic [7:0] lc;
    lc = fold_case(c);
    if (is_dig(c)) return {1'b0, c[3:0]};
    if (lc >= 8'h61 && lc <= 8'h66) return 5'(lc - 8'h61 + 8'd10);
    return 5'd16;
  endfunction

  function automatic hrd_state_t clear_line(input hrd_state_t s);
    hrd_state_t r;
    r = s;
    r.line_nonempty  = 1'b0;
    r.colon_seen     = 1'b0;
    r.key_position   = '0;
    r.key_candidates = 3'b111;
    r.key_gap        = 1'b0;
    r.chunked_match  = '0;
    r.close_match    = '0;
    return r;
  endfunction

  function automatic logic cl_ok(input logic [4:0] p, input logic [7:0] lc);
    if (p >= 5'd14) return 1'b0;
    return NAME_CL[8*(13 - int'(p)) +: 8] == lc;
  endfunction

  function automatic logic te_ok(input logic [4:0] p, input logic [7:0] lc);
    if (p >= 5'd17) return 1'b0;
    return NAME_TE[8*(16 - int'(p)) +: 8] == lc;
  endfunction

  function automatic logic conn_ok(input logic [4:0] p, input logic [7:0] lc);
    if (p >= 5'd10) return 1'b0;
    return NAME_CONN[8*(9 - int'(p)) +: 8] == lc;
  endfunction

  // One step of a substring search; the words hold their first letter once.
  function automatic logic [2:0] match_step(input logic [2:0] m, input logic [7:0] c,
                                            input logic [8*7-1:0] pat,
                                            input logic [2:0] len);
    if (m >= len) return len;
    if (c == pat[8*(6 - int'(m)) +: 8]) return m + 3'd1;
    return (c == pat[55:48]) ? 3'd1 : 3'd0;
  endfunction

  function automatic hrd_result_t make_result(input kind_t k, input logic [7:0] b,
                                              input logic [9:0] code, input logic ka);
    hrd_result_t r;
    r.result_kind = k;
    r.body_byte   = b;
    r.resp_code   = code;
    r.reuse_ok    = ka;
    r.last        = 1'b0;
    return r;
  endfunction

endpackage

FILE: hdl/hrd_in_if.sv
// Input channel carrying stream bytes and connection-close events.
interface hrd_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] data_byte;

  modport source(output valid, output operation, output data_byte, input ready);
  modport sink(input valid, input operation, input data_byte, output ready);
endinterface

FILE: hdl/hrd_out_if.sv
// Output channel carrying body bytes, completions and errors.
interface hrd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [7:0] body_byte;
  logic [9:0] resp_code;
  logic       reuse_ok;
  logic       last;

  modport source(output valid, output result_kind, output body_byte,
                 output resp_code, output reuse_ok, output last, input ready);
  modport sink(input valid, input result_kind, input body_byte,
               input resp_code, input reuse_ok, input last, output ready);
endinterface

FILE: hdl/hrd_result_fifo.sv
// Four-entry result queue that takes up to two results and gives one per cycle on pop.
module hrd_result_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic [1:0]          push_count,
  input  hrd_pkg::hrd_result_t push0,
  input  hrd_pkg::hrd_result_t push1,
  input  logic                pop,
  output hrd_pkg::hrd_result_t head,
  output logic [2:0]          count
);
  import hrd_pkg::*;

  hrd_result_t entries [4];
  logic [1:0]  wr_ptr;
  logic [1:0]  rd_ptr;

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      entries[wr_ptr] <= push0;
    end
    if (push_count == 2'd2) begin
      entries[wr_ptr + 2'd1] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_count;
      rd_ptr <= rd_ptr + {1'b0, pop};
      count  <= count + {1'b0, push_count} - {2'b00, pop};
    end
  end

  assign head = entries[rd_ptr];

endmodule

FILE: hdl/http_response_deframer_core.sv
// Top level of the HTTP response deframer: parser state and result queue.
//
//   channel | dir | beat carries
//   stream  | in  | operation, data_byte
//   result  | out | result_kind, body_byte, resp_code, reuse_ok, last
//
// A stream beat is registered, then parsed combinationally into zero to two
// results that enter a four-entry result queue, whose registered entries feed
// the result port. One beat is taken every cycle while the result side is
// ready and each beat gives at most one result; the final body byte of a
// content-length response gives two, and the queue's single output port then
// paces the stream. Reset is synchronous and returns the parser to the status
// line. A stalled result side fills the queue and then holds stream ready low.
module http_response_deframer_core #(
  parameter int LENGTH_BITS = hrd_pkg::LENGTH_BITS_DEFAULT
) (
  input logic     clk,
  input logic     rst,
  hrd_in_if.sink  stream,
  hrd_out_if.source result
);
  import hrd_pkg::*;
  `include "http_response_deframer_core_defines.svh"

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

  typedef struct packed {
    hrd_state_t             s;
    logic [LENGTH_BITS-1:0] len;
    logic [LENGTH_BITS-1:0] rem;
  } ctx_t;

  ctx_t        ctx;
  ctx_t        ctx_next;
  logic        s1_valid;
  logic        s1_op;
  logic [7:0]  s1_byte;
  logic        s1_fire;
  logic [1:0]  step_n;
  hrd_result_t res0;
  hrd_result_t res1;
  hrd_result_t head;
  logic [2:0]  fifo_count;
  kind_t       final_kind;

  function automatic logic [LENGTH_BITS-1:0] sat10(input logic [LENGTH_BITS-1:0] v,
                                                   input logic [3:0] d);
    logic [LENGTH_BITS+3:0] t;
    t = ({4'b0, v} << 3) + ({4'b0, v} << 1) + {{LENGTH_BITS{1'b0}}, d};
    return (t[LENGTH_BITS+3:LENGTH_BITS] != 4'd0) ? LEN_MAX : t[LENGTH_BITS-1:0];
  endfunction

  function automatic logic [LENGTH_BITS-1:0] sat16(input logic [LENGTH_BITS-1:0] v,
                                                   input logic [3:0] h);
    return (v[LENGTH_BITS-1:LENGTH_BITS-4] != 4'd0) ? LEN_MAX
                                                   : {v[LENGTH_BITS-5:0], h};
  endfunction

  function automatic ctx_t key_char(input ctx_t x, input logic [7:0] c);
    ctx_t       r;
    logic [4:0] p;
    logic [2:0] cand;
    logic [7:0] lc;
    r = x;
    p = x.s.key_position;
    lc = fold_case(c);
    cand = '0;
    if (c == CH_COLON) begin
      cand[CAND_CL]   = x.s.key_candidates[CAND_CL] && p == 5'd14;
      cand[CAND_TE]   = x.s.key_candidates[CAND_TE] && p == 5'd17;
      cand[CAND_CONN] = x.s.key_candidates[CAND_CONN] && p == 5'd10;
      r.s.key_candidates = cand;
      r.s.colon_seen = 1'b1;
      r.s.key_position = '0;
      r.s.chunked_match = '0;
      r.s.close_match = '0;
      if (cand[CAND_CL]) begin
        r.len = '0;
        r.s.length_valid = 1'b1;
      end
    end else if (is_ws(c)) begin
      if (p != 5'd0) r.s.key_gap = 1'b1;
    end else if (x.s.key_gap) begin
      r.s.key_candidates = '0;
    end else begin
      if (!cl_ok(p, lc)) r.s.key_candidates[CAND_CL] = 1'b0;
      if (!te_ok(p, lc)) r.s.key_candidates[CAND_TE] = 1'b0;
      if (!conn_ok(p, lc)) r.s.key_candidates[CAND_CONN] = 1'b0;
      if (p < 5'd31) r.s.key_position = p + 5'd1;
    end
    return r;
  endfunction

  function automatic ctx_t value_char(input ctx_t x, input logic [7:0] c);
    ctx_t       r;
    logic [7:0] lc;
    r = x;
    lc = fold_case(c);
    if (x.s.key_candidates[CAND_CL]) begin
      unique case (x.s.key_position)
        5'd0: begin
          if (is_ws(c)) begin
            r.s.key_position = 5'd0;
          end else if (c == CH_PLUS) begin
            r.s.key_position = 5'd1;
          end else if (c == CH_MINUS) begin
            r.s.length_valid = 1'b0;
            r.s.key_position = 5'd3;
          end else if (is_dig(c)) begin
            r.len = {{(LENGTH_BITS-4){1'b0}}, c[3:0]};
            r.s.key_position = 5'd2;
          end else begin
            r.s.key_position = 5'd3;
          end
        end
        5'd1, 5'd2: begin
          if (is_dig(c)) begin
            r.len = sat10(x.len, c[3:0]);
            r.s.key_position = 5'd2;
          end else begin
            r.s.key_position = 5'd3;
          end
        end
        default: r.s.key_position = x.s.key_position;
      endcase
    end
    if (x.s.key_candidates[CAND_TE] && !x.s.chunked_flag) begin
      r.s.chunked_match = match_step(x.s.chunked_match, lc, WORD_CHUNKED, LEN_CHUNKED);
      if (r.s.chunked_match == LEN_CHUNKED) r.s.chunked_flag = 1'b1;
    end
    if (x.s.key_candidates[CAND_CONN]) begin
      r.s.close_match = match_step(x.s.close_match, lc, WORD_CLOSE, LEN_CLOSE);
      if (r.s.close_match == LEN_CLOSE) r.s.keep_flag = 1'b0;
    end
    return r;
  endfunction

  function automatic ctx_t size_char(input ctx_t x, input logic [7:0] c);
    ctx_t       r;
    logic [4:0] h;
    r = x;
    h = hexval(c);
    if (x.s.size_done) return r;
    if (c == CH_SEMI) begin
      r.s.size_done = 1'b1;
      return r;
    end
    unique case (x.s.space_count)
      2'd0: begin
        if (is_ws(c)) begin
          r.s.space_count = 2'd0;
        end else if (c == CH_ZERO) begin
          r.s.space_count = 2'd1;
        end else if (!h[4]) begin
          r.rem = {{(LENGTH_BITS-4){1'b0}}, h[3:0]};
          r.s.space_count = 2'd3;
        end else begin
          r.s.size_done = 1'b1;
        end
      end
      2'd1: begin
        if (c == CH_X_LO || c == CH_X_UP) begin
          r.s.space_count = 2'd2;
        end else if (!h[4]) begin
          r.rem = {{(LENGTH_BITS-4){1'b0}}, h[3:0]};
          r.s.space_count = 2'd3;
        end else begin
          r.s.size_done = 1'b1;
        end
      end
      2'd2: begin
        if (!h[4]) begin
          r.rem = {{(LENGTH_BITS-4){1'b0}}, h[3:0]};
          r.s.space_count = 2'd3;
        end else begin
          r.s.size_done = 1'b1;
        end
      end
      default: begin
        if (!h[4]) r.rem = sat16(x.rem, h[3:0]);
        else r.s.size_done = 1'b1;
      end
    endcase
    return r;
  endfunction

  function automatic ctx_t line_char(input ctx_t x, input logic [7:0] c);
    ctx_t        r;
    logic [13:0] t;
    r = x;
    t = ({4'b0, x.s.code_value} << 3) + ({4'b0, x.s.code_value} << 1)
        + {10'b0, c[3:0]};
    if (x.s.phase == PH_STATUS) begin
      if (c == CH_SPACE) begin
        if (x.s.space_count < 2'd2) r.s.space_count = x.s.space_count + 2'd1;
      end else if (x.s.space_count == 2'd1) begin
        if (is_dig(c)) r.s.code_value = (t > 14'(CODE_MAX)) ? CODE_MAX : t[9:0];
        else r.s.space_count = 2'd2;
      end
    end else if (x.s.phase == PH_HEADER) begin
      r.s.line_nonempty = 1'b1;
      if (x.s.colon_seen) r = value_char(r, c);
      else r = key_char(r, c);
    end else if (x.s.phase == PH_SIZE) begin
      r = size_char(x, c);
    end
    return r;
  endfunction

  // Input register.
  assign s1_fire = s1_valid && (fifo_count <= 3'd2);
  assign stream.ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (stream.ready) begin
      s1_valid <= stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stream.valid && stream.ready) begin
      s1_op   <= stream.operation;
      s1_byte <= stream.data_byte;
    end
  end

  // One parser step per registered beat.
  always_comb begin
    ctx_t x;
    logic fin;
    x = ctx;
    fin = 1'b0;
    step_n = 2'd0;
    res0 = '0;
    res1 = '0;
    if (s1_op == OP_CLOSE) begin
      step_n = 2'd1;
      if (x.s.phase == PH_UNTIL_CLOSE) begin
        res0 = make_result(KIND_DONE, 8'd0, x.s.code_value, 1'b0);
      end else if (x.s.phase == PH_TRAILER) begin
        res0 = make_result(KIND_DONE, 8'd0, x.s.code_value, x.s.keep_flag);
      end else begin
        res0 = make_result(KIND_ERROR, 8'd0, 10'd0, 1'b0);
      end
      fin = 1'b1;
    end else if (x.s.phase == PH_LENGTH || x.s.phase == PH_UNTIL_CLOSE ||
                 x.s.phase == PH_DATA) begin
      res0 = make_result(KIND_BODY, s1_byte, 10'd0, 1'b0);
      step_n = 2'd1;
      if (x.s.phase != PH_UNTIL_CLOSE) begin
        if (x.rem != '0) x.rem = x.rem - 1'b1;
        if (x.rem == '0) begin
          if (x.s.phase == PH_LENGTH) begin
            res1 = make_result(KIND_DONE, 8'd0, x.s.code_value, x.s.keep_flag);
            step_n = 2'd2;
            fin = 1'b1;
          end else begin
            x.s.phase = PH_GAP;
            x.rem = LENGTH_BITS'(2);
          end
        end
      end
    end else if (x.s.phase == PH_GAP) begin
      if (x.rem != '0) x.rem = x.rem - 1'b1;
      if (x.rem == '0) begin
        x.s.phase = PH_SIZE;
        x.s.held_cr = 1'b0;
        x.s.space_count = '0;
        x.s.size_done = 1'b0;
      end
    end else if (x.s.held_cr && s1_byte == CH_LF) begin
      x.s.held_cr = 1'b0;
      if (x.s.phase == PH_STATUS) begin
        if (x.s.space_count == 2'd0) begin
          res0 = make_result(KIND_ERROR, 8'd0, 10'd0, 1'b0);
          step_n = 2'd1;
          fin = 1'b1;
        end else begin
          x.s = clear_line(x.s);
          x.s.phase = PH_HEADER;
        end
      end else if (x.s.phase == PH_HEADER) begin
        if (x.s.line_nonempty) begin
          x.s = clear_line(x.s);
        end else begin
          x.s.space_count = '0;
          x.s.size_done = 1'b0;
          if (x.s.chunked_flag) begin
            x.s.phase = PH_SIZE;
            x.rem = '0;
          end else if (x.s.length_valid) begin
            if (x.len == '0) begin
              res0 = make_result(KIND_DONE, 8'd0, x.s.code_value, x.s.keep_flag);
              step_n = 2'd1;
              fin = 1'b1;
            end else begin
              x.s.phase = PH_LENGTH;
              x.rem = x.len;
            end
          end else begin
            x.s.phase = PH_UNTIL_CLOSE;
          end
        end
      end else if (x.s.phase == PH_SIZE) begin
        x.s.phase = (x.rem == '0) ? PH_TRAILER : PH_DATA;
        x.s.space_count = '0;
        x.s.size_done = 1'b0;
      end else begin
        res0 = make_result(KIND_DONE, 8'd0, x.s.code_value, x.s.keep_flag);
        step_n = 2'd1;
        fin = 1'b1;
      end
    end else begin
      if (x.s.held_cr) begin
        x.s.held_cr = 1'b0;
        x = line_char(x, CH_CR);
      end
      if (s1_byte == CH_CR) x.s.held_cr = 1'b1;
      else x = line_char(x, s1_byte);
    end
    if (fin) begin
      x.s = HRD_STATE_RESET;
      x.len = '0;
      x.rem = '0;
    end
    if (step_n == 2'd1) res0.last = 1'b1;
    if (step_n == 2'd2) res1.last = 1'b1;
    ctx_next = x;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctx.s   <= HRD_STATE_RESET;
      ctx.len <= '0;
      ctx.rem <= '0;
    end else if (s1_fire) begin
      ctx <= ctx_next;
    end
  end

  hrd_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_count(s1_fire ? step_n : 2'd0),
    .push0     (res0),
    .push1     (res1),
    .pop       (result.valid && result.ready),
    .head      (head),
    .count     (fifo_count)
  );

  assign result.valid       = fifo_count != 3'd0;
  assign result.result_kind = head.result_kind;
  assign result.body_byte   = head.body_byte;
  assign result.resp_code   = head.resp_code;
  assign result.reuse_ok    = head.reuse_ok;
  assign result.last        = head.last;

  assign final_kind = (step_n == 2'd2) ? res1.result_kind : res0.result_kind;

  `HRD_ASSERT_NOW(a_queue_bound, 1'b1, fifo_count <= 3'd4, "result queue overflow")
  `HRD_ASSERT_NOW(a_close_one, s1_fire && s1_op == OP_CLOSE, step_n == 2'd1,
                  "close must give exactly one result")
  `HRD_ASSERT_NEXT(a_end_to_status,
                   s1_fire && step_n != 2'd0 && final_kind != KIND_BODY,
                   ctx.s.phase == PH_STATUS, "completion must return to status line")
  `HRD_ASSERT_NOW(a_body_phase,
                  s1_fire && step_n != 2'd0 && res0.result_kind == KIND_BODY,
                  ctx.s.phase == PH_LENGTH || ctx.s.phase == PH_UNTIL_CLOSE ||
                  ctx.s.phase == PH_DATA, "body byte outside a body phase")

endmodule

FILE: bench/tb_top.sv
// Self-checking testbench of the HTTP response deframer: directed table, then random responses.
module tb_top;
  import hrd_pkg::*;

  localparam int        RUN_LIMIT = 400000;
  localparam int        HOLD_CYCLES = 300;
  localparam logic [63:0] LEN_MAX = 64'h0000_0000_FFFF_FFFF;

  typedef struct packed {
    op_t        op;
    logic [7:0] b;
  } beat_t;

  typedef struct {
    op_t         op;
    logic [7:0]  b;
    bit          typed;
    hrd_result_t res;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  hrd_in_if  stream_if();
  hrd_out_if result_if();

  http_response_deframer_core u_top (
    .clk    (clk),
    .rst    (rst),
    .stream (stream_if.sink),
    .result (result_if.source)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  hrd_result_t expected_results[$];
  hrd_result_t step_out[$];
  beat_t       stim_q[$];
  row_t        rows[$];
  int          errors = 0;
  int          cycles = 0;
  int          src_idle = 0;
  int          snk_idle = 0;
  int          hold_left = 0;
  bit          hold_req = 1'b0;
  bit          hold_taken = 1'b0;

  phase_t      pst;
  logic        cr_pend, nonempty, colon, kgap, lenok, chk, keep, szdone;
  logic [1:0]  spc;
  logic [9:0]  code;
  logic [4:0]  kpos;
  logic [2:0]  cand, chm, clm;
  logic [63:0] lenv, rem;

  function automatic logic white(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic [7:0] low_case(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] lc;
    lc = low_case(c);
    if (c >= "0" && c <= "9") return 5'(c - "0");
    if (lc >= "a" && lc <= "f") return 5'(lc - "a" + 10);
    return 5'd16;
  endfunction

  function automatic logic [63:0] sat_mac(input logic [63:0] v, input int base,
                                          input logic [4:0] d);
    if (v > (LEN_MAX - d) / base) return LEN_MAX;
    return v * base + d;
  endfunction

  function automatic logic [2:0] word_step(input logic [2:0] m, input logic [7:0] c,
                                           input string w);
    if (m >= w.len()) return 3'(w.len());
    if (c == w[m]) return m + 3'd1;
    return (c == w[0]) ? 3'd1 : 3'd0;
  endfunction

  task automatic new_line();
    nonempty = 0; colon = 0; kpos = 0; cand = 3'b111; kgap = 0; chm = 0; clm = 0;
  endtask

  task automatic new_response();
    pst = PH_STATUS; cr_pend = 0; spc = 0; code = 0;
    new_line();
    lenv = 0; lenok = 0; chk = 0; keep = 1; rem = 0; szdone = 0;
  endtask

  task automatic put(input kind_t k, input logic [7:0] b, input logic [9:0] c,
                     input logic ka);
    hrd_result_t r;
    r.result_kind = k; r.body_byte = b; r.resp_code = c; r.reuse_ok = ka; r.last = 0;
    step_out.push_back(r);
  endtask

  task automatic finish_response(input logic ka);
    put(KIND_DONE, 8'h00, code, ka);
    new_response();
  endtask

  task automatic abort_response();
    put(KIND_ERROR, 8'h00, 10'd0, 1'b0);
    new_response();
  endtask

  task automatic key_byte(input logic [7:0] c);
    string      n_cl, n_te, n_co;
    logic [2:0] nc;
    logic [7:0] lc;
    n_cl = "content-length"; n_te = "transfer-encoding"; n_co = "connection";
    if (c == CH_COLON) begin
      nc = 0;
      if (cand[CAND_CL] && kpos == 14) nc[CAND_CL] = 1;
      if (cand[CAND_TE] && kpos == 17) nc[CAND_TE] = 1;
      if (cand[CAND_CONN] && kpos == 10) nc[CAND_CONN] = 1;
      cand = nc; colon = 1; kpos = 0; chm = 0; clm = 0;
      if (nc[CAND_CL]) begin
        lenv = 0; lenok = 1;
      end
    end else if (white(c)) begin
      if (kpos != 0) kgap = 1;
    end else if (kgap) begin
      cand = 0;
    end else begin
      lc = low_case(c);
      if (kpos >= 14 || n_cl[kpos] != lc) cand[CAND_CL] = 0;
      if (kpos >= 17 || n_te[kpos] != lc) cand[CAND_TE] = 0;
      if (kpos >= 10 || n_co[kpos] != lc) cand[CAND_CONN] = 0;
      if (kpos < 31) kpos = kpos + 1;
    end
  endtask

  task automatic value_byte(input logic [7:0] c);
    logic       dig;
    logic [7:0] lc;
    dig = c >= "0" && c <= "9";
    lc = low_case(c);
    if (cand[CAND_CL]) begin
      case (kpos)
        5'd0: begin
          if (!white(c)) begin
            if (c == CH_PLUS) kpos = 1;
            else if (c == CH_MINUS) begin
              lenok = 0; kpos = 3;
            end else if (dig) begin
              lenv = 64'(c - "0"); kpos = 2;
            end else kpos = 3;
          end
        end
        5'd1, 5'd2: begin
          if (dig) begin
            lenv = sat_mac(lenv, 10, 5'(c - "0")); kpos = 2;
          end else kpos = 3;
        end
        default: ;
      endcase
    end
    if (cand[CAND_TE] && !chk) begin
      chm = word_step(chm, lc, "chunked");
      if (chm == 7) chk = 1;
    end
    if (cand[CAND_CONN]) begin
      clm = word_step(clm, lc, "close");
      if (clm == 5) keep = 0;
    end
  endtask

  task automatic size_byte(input logic [7:0] c);
    logic [4:0] h;
    h = hex_digit(c);
    if (szdone) return;
    if (c == CH_SEMI) begin
      szdone = 1;
      return;
    end
    case (spc)
      2'd0: begin
        if (white(c)) return;
        if (c == CH_ZERO) spc = 1;
        else if (h < 16) begin
          rem = h; spc = 3;
        end else szdone = 1;
      end
      2'd1: begin
        if (c == CH_X_LO || c == CH_X_UP) spc = 2;
        else if (h < 16) begin
          rem = h; spc = 3;
        end else szdone = 1;
      end
      2'd2: begin
        if (h < 16) begin
          rem = h; spc = 3;
        end else szdone = 1;
      end
      default: begin
        if (h < 16) rem = sat_mac(rem, 16, h);
        else szdone = 1;
      end
    endcase
  endtask

  task automatic line_byte(input logic [7:0] c);
    logic [13:0] v;
    if (pst == PH_STATUS) begin
      if (c == CH_SPACE) begin
        if (spc < 2) spc = spc + 1;
      end else if (spc == 1) begin
        if (c >= "0" && c <= "9") begin
          v = code * 10 + (c - "0");
          code = (v > 999) ? CODE_MAX : v[9:0];
        end else spc = 2;
      end
    end else if (pst == PH_HEADER) begin
      nonempty = 1;
      if (colon) value_byte(c);
      else key_byte(c);
    end else if (pst == PH_SIZE) begin
      size_byte(c);
    end
  endtask

  task automatic line_done();
    if (pst == PH_STATUS) begin
      if (spc == 0) abort_response();
      else begin
        pst = PH_HEADER; new_line();
      end
    end else if (pst == PH_HEADER) begin
      if (nonempty) new_line();
      else begin
        spc = 0; szdone = 0;
        if (chk) begin
          pst = PH_SIZE; rem = 0;
        end else if (lenok) begin
          if (lenv == 0) finish_response(keep);
          else begin
            pst = PH_LENGTH; rem = lenv;
          end
        end else pst = PH_UNTIL_CLOSE;
      end
    end else if (pst == PH_SIZE) begin
      pst = (rem == 0) ? PH_TRAILER : PH_DATA;
      spc = 0; szdone = 0;
    end else finish_response(keep);
  endtask

  task automatic deframe_step(input beat_t bt);
    logic lf_taken;
    step_out.delete();
    lf_taken = 0;
    if (bt.op == OP_CLOSE) begin
      if (pst == PH_UNTIL_CLOSE) finish_response(1'b0);
      else if (pst == PH_TRAILER) finish_response(keep);
      else abort_response();
    end else if (pst == PH_LENGTH || pst == PH_UNTIL_CLOSE || pst == PH_DATA) begin
      put(KIND_BODY, bt.b, 10'd0, 1'b0);
      if (pst != PH_UNTIL_CLOSE) begin
        if (rem != 0) rem = rem - 1;
        if (rem == 0) begin
          if (pst == PH_LENGTH) finish_response(keep);
          else begin
            pst = PH_GAP; rem = 2;
          end
        end
      end
    end else if (pst == PH_GAP) begin
      if (rem != 0) rem = rem - 1;
      if (rem == 0) begin
        pst = PH_SIZE; cr_pend = 0; spc = 0; szdone = 0;
      end
    end else begin
      if (cr_pend) begin
        cr_pend = 0;
        if (bt.b == CH_LF) begin
          line_done();
          lf_taken = 1;
        end else line_byte(CH_CR);
      end
      if (!lf_taken) begin
        if (bt.b == CH_CR) cr_pend = 1;
        else line_byte(bt.b);
      end
    end
    if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
  endtask

  task automatic add_text(input string s);
    beat_t bt;
    for (int i = 0; i < s.len(); i++) begin
      bt.op = OP_DATA; bt.b = s[i];
      stim_q.push_back(bt);
    end
  endtask

  task automatic add_close();
    beat_t bt;
    bt.op = OP_CLOSE; bt.b = 8'($urandom_range(0, 255));
    stim_q.push_back(bt);
  endtask

  task automatic add_body(input int n);
    beat_t bt;
    for (int i = 0; i < n; i++) begin
      bt.op = OP_DATA; bt.b = 8'($urandom_range(0, 255));
      stim_q.push_back(bt);
    end
  endtask

  function automatic string mix_case(input string s);
    string r;
    r = s;
    for (int i = 0; i < r.len(); i++)
      if ($urandom_range(0, 1) && r[i] >= "a" && r[i] <= "z") r[i] = r[i] - 8'd32;
    return r;
  endfunction

  task automatic add_response();
    int    nd, len, n;
    bit    te, cl_neg, cl_set;
    string s;
    te = 0; cl_set = 0; cl_neg = 0; len = 0;
    if ($urandom_range(0, 99) < 8) begin
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 4) == 0) add_close();
        else add_body(1);
      end
      return;
    end
    s = ($urandom_range(0, 9) == 0) ? "HTTP\r/1.1 " : "HTTP/1.1 ";
    nd = $urandom_range(0, 4);
    for (int i = 0; i < nd; i++) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
    add_text({s, " OK\r\n"});
    n = $urandom_range(0, 4);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 5))
        0: begin
          cl_set = 1;
          if ($urandom_range(0, 5) == 0) begin
            cl_neg = 1; add_text({mix_case("content-length"), ": -1\r\n"});
          end else begin
            cl_neg = 0; len = $urandom_range(0, 6);
            add_text({" ", mix_case("content-length"), " :\t",
                      ($urandom_range(0, 1) ? "+" : ""), $sformatf("%0d", len), "\r\n"});
          end
        end
        1: begin
          te = 1; add_text({mix_case("transfer-encoding"), ": gzip, ", mix_case("chunked"), "\r\n"});
        end
        2: add_text({mix_case("connection"), ": ", ($urandom_range(0, 1) ? "close" : "keep-alive"),
                     "\r\n"});
        3: add_text("content length: 5\r\n");
        4: add_text("NoColonHere\r\n");
        default: add_text("Server: x\r\n");
      endcase
    end
    if ($urandom_range(0, 19) == 0) begin
      add_close();
      return;
    end
    add_text("\r\n");
    if (te) begin
      n = $urandom_range(0, 3);
      for (int i = 0; i < n; i++) begin
        len = $urandom_range(1, 5);
        add_text({($urandom_range(0, 1) ? " 0x" : ""), $sformatf("%0h", len),
                  ($urandom_range(0, 1) ? ";ext=1" : ""), "\r\n"});
        add_body(len + 2);
      end
      add_text("0\r\n");
      if ($urandom_range(0, 3) == 0) add_close();
      else add_text("\r\n");
    end else if (cl_set && !cl_neg) begin
      add_body(len);
    end else begin
      add_body($urandom_range(0, 6));
      add_close();
    end
  endtask

  task automatic add_row(input op_t op, input logic [7:0] b, input bit typed,
                         input kind_t k, input logic [9:0] c, input logic ka);
    row_t r;
    r.op = op; r.b = b; r.typed = typed;
    r.res.result_kind = k; r.res.body_byte = 8'h00; r.res.resp_code = c;
    r.res.reuse_ok = ka; r.res.last = 1'b1;
    rows.push_back(r);
  endtask

  task automatic add_row_text(input string s);
    for (int i = 0; i < s.len(); i++) add_row(OP_DATA, s[i], 0, KIND_BODY, 10'd0, 1'b0);
  endtask

  task automatic send_beat(input beat_t bt, input bit typed, input hrd_result_t fixed);
    while ($urandom_range(0, 99) < src_idle) begin
      stream_if.valid <= 1'b0;
      @(negedge clk);
    end
    stream_if.valid     <= 1'b1;
    stream_if.operation <= bt.op;
    stream_if.data_byte <= bt.b;
    do @(posedge clk); while (!stream_if.ready);
    deframe_step(bt);
    if (typed) begin
      step_out.delete();
      step_out.push_back(fixed);
    end
    foreach (step_out[i]) expected_results.push_back(step_out[i]);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= HOLD_CYCLES;
      result_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= ($urandom_range(0, 99) >= snk_idle);
    end
  end

  always @(posedge clk) begin
    hrd_result_t got, want;
    if (!rst && result_if.valid && result_if.ready) begin
      got.result_kind = kind_t'(result_if.result_kind);
      got.body_byte   = result_if.body_byte;
      got.resp_code   = result_if.resp_code;
      got.reuse_ok    = result_if.reuse_ok;
      got.last        = result_if.last;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result beat kind=%0d byte=%h code=%0d ka=%0d last=%0d",
                 $time, got.result_kind, got.body_byte, got.resp_code, got.reuse_ok,
                 got.last);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected kind=%0d byte=%h code=%0d ka=%0d last=%0d",
                   $time, want.result_kind, want.body_byte, want.resp_code,
                   want.reuse_ok, want.last);
          $display("%0t:          actual   kind=%0d byte=%h code=%0d ka=%0d last=%0d",
                   $time, got.result_kind, got.body_byte, got.resp_code, got.reuse_ok,
                   got.last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > RUN_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    beat_t       bt;
    hrd_result_t none;
    int          sent;
    none = '0;
    stream_if.valid     <= 1'b0;
    stream_if.operation <= OP_DATA;
    stream_if.data_byte <= 8'h00;
    new_response();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    add_row(OP_CLOSE, 8'h00, 1, KIND_ERROR, 10'd0, 1'b0);
    add_row(OP_DATA, "X", 0, KIND_BODY, 10'd0, 1'b0);
    add_row(OP_DATA, CH_CR, 0, KIND_BODY, 10'd0, 1'b0);
    add_row(OP_DATA, CH_LF, 1, KIND_ERROR, 10'd0, 1'b0);
    add_row_text(" 9999\r\n\r\n");
    add_row(OP_DATA, 8'h00, 0, KIND_BODY, 10'd0, 1'b0);
    add_row(OP_DATA, 8'hFF, 0, KIND_BODY, 10'd0, 1'b0);
    add_row(OP_CLOSE, 8'hFF, 1, KIND_DONE, CODE_MAX, 1'b0);
    add_row_text("H 204\r\n\r\n");
    foreach (rows[i]) begin
      bt.op = rows[i].op; bt.b = rows[i].b;
      send_beat(bt, rows[i].typed, rows[i].res);
    end

    for (int ph = 0; ph < 3; ph++) begin
      src_idle = (ph == 0) ? 9 : (ph == 1) ? 79 : 0;
      snk_idle = (ph == 0) ? 79 : (ph == 1) ? 9 : 0;
      if (ph == 1) hold_req = 1'b1;
      sent = 0;
      while (sent < 300) begin
        if (stim_q.size() == 0) add_response();
        send_beat(stim_q.pop_front(), 0, none);
        sent++;
      end
      while (stim_q.size() > 0) send_beat(stim_q.pop_front(), 0, none);
      stream_if.valid <= 1'b0;
      while (expected_results.size() > 0) @(posedge clk);
      @(negedge clk);
    end

    repeat (20) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
